FILE: src/lla_pkg.sv
package lla_pkg;

  // Default store size
  localparam int MaxRowsDef = 32;
  localparam int MaxColsDef = 128;

  // Item kinds carried on s_tuser
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SURVIVE_MIN = 3'd0;
  localparam logic [2:0] REG_SURVIVE_MAX = 3'd1;
  localparam logic [2:0] REG_BIRTH_MIN   = 3'd2;
  localparam logic [2:0] REG_BIRTH_MAX   = 3'd3;
  localparam logic [2:0] REG_ROWS_IN_USE = 3'd4;
  localparam logic [2:0] REG_COLS_IN_USE = 3'd5;

  // Reset values of the configuration registers
  localparam logic [3:0] SURVIVE_MIN_RST = 4'd2;
  localparam logic [3:0] SURVIVE_MAX_RST = 4'd3;
  localparam logic [3:0] BIRTH_MIN_RST   = 4'd3;
  localparam logic [3:0] BIRTH_MAX_RST   = 4'd3;
  localparam logic [5:0] ROWS_IN_USE_RST = 6'd25;
  localparam logic [7:0] COLS_IN_USE_RST = 8'd80;

  typedef struct packed {
    logic [3:0] survive_min;
    logic [3:0] survive_max;
    logic [3:0] birth_min;
    logic [3:0] birth_max;
  } rule_t;

endpackage

FILE: src/lla_row_mem.sv
module lla_row_mem
  import lla_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_ROWS)-1:0] wr_addr,
  input  logic [MAX_COLS-1:0]         wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_ROWS)-1:0] rd_addr,
  output logic [MAX_COLS-1:0]         rd_data
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [MAX_COLS-1:0] rd_q;
  logic                rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // a row never written since reset reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

FILE: src/lla_cell_unit.sv
module lla_cell_unit
  import lla_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDef
) (
  input  logic [MAX_COLS-1:0]           prev_row,
  input  logic [MAX_COLS-1:0]           cur_row,
  input  logic [MAX_COLS-1:0]           next_row,
  input  logic [$clog2(MAX_COLS)-1:0]   col,
  input  logic [$clog2(MAX_COLS+1)-1:0] ncols,
  input  rule_t                         rules,
  output logic                          alive
);

  localparam int CAW = $clog2(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS+1);

  logic [CAW-1:0] col_l;
  logic [CAW-1:0] col_r;
  logic [CNW-1:0] col_p1;
  logic [3:0]     count;
  logic           self;

  always_comb begin
    col_p1 = CNW'(col) + CNW'(1);
    col_l  = (col == '0) ? CAW'(ncols - CNW'(1)) : col - CAW'(1);
    col_r  = (col_p1 >= ncols) ? '0 : CAW'(col_p1);
    self   = cur_row[col];
    count  = 4'(prev_row[col_l]) + 4'(prev_row[col]) + 4'(prev_row[col_r])
           + 4'(cur_row[col_l])  + 4'(cur_row[col_r])
           + 4'(next_row[col_l]) + 4'(next_row[col]) + 4'(next_row[col_r]);
    if (self) begin
      alive = (count >= rules.survive_min) && (count <= rules.survive_max);
    end else begin
      alive = (count >= rules.birth_min) && (count <= rules.birth_max);
    end
  end

endmodule

FILE: src/life_like_automaton_step_top.sv
// Life-like automaton on a wrapped grid of one-bit cells, held as one row per
// memory word. Write and read items read the addressed row first and then go
// to the output transfer (an out-of-grid coordinate or an unused kind goes
// there directly). A step item sweeps the grid in use row by row, with one
// neighbor count and rule check per cycle on the single cell unit, plus a row
// read and a row write-back per row on the simple dual-port row memory.
// The update runs in place; the original of the row above and of row 0 are
// kept in row registers. Cells outside the grid in use are left as they are.
// No clearing pass: per-row valid bits make the store read as dead at reset.
// A new item is taken while a finished result still waits on the output.
module life_like_automaton_step_top
  import lla_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row[4:0], col[11:5], cell_in[12], zero fill
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cell_out[0], live_count[13:1], zero fill
  output logic [0:0]  m_tuser    // status[0]
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int RNW = $clog2(MAX_ROWS+1);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS+1);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ACC       = 4'd1;
  localparam logic [3:0] ST_LD_PREV   = 4'd2;
  localparam logic [3:0] ST_LD_FIRST  = 4'd3;
  localparam logic [3:0] ST_NEXT_RD   = 4'd4;
  localparam logic [3:0] ST_NEXT_WAIT = 4'd5;
  localparam logic [3:0] ST_SWEEP     = 4'd6;
  localparam logic [3:0] ST_WB        = 4'd7;
  localparam logic [3:0] ST_OUT       = 4'd8;

  // configuration
  rule_t      rules;
  logic [5:0] rows_in_use;
  logic [7:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rules.survive_min <= SURVIVE_MIN_RST;
      rules.survive_max <= SURVIVE_MAX_RST;
      rules.birth_min   <= BIRTH_MIN_RST;
      rules.birth_max   <= BIRTH_MAX_RST;
      rows_in_use       <= ROWS_IN_USE_RST;
      cols_in_use       <= COLS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SURVIVE_MIN: rules.survive_min <= cfg_data[3:0];
        REG_SURVIVE_MAX: rules.survive_max <= cfg_data[3:0];
        REG_BIRTH_MIN:   rules.birth_min   <= cfg_data[3:0];
        REG_BIRTH_MAX:   rules.birth_max   <= cfg_data[3:0];
        REG_ROWS_IN_USE: rows_in_use       <= cfg_data[5:0];
        REG_COLS_IN_USE: cols_in_use       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // grid size in use: zero acts as one, beyond the store acts as the store
  logic [RNW-1:0] nrows;
  logic [CNW-1:0] ncols;
  logic [RAW-1:0] last_row;
  logic [CAW-1:0] last_col;

  always_comb begin
    if (rows_in_use == '0) begin
      nrows = RNW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      nrows = RNW'(MAX_ROWS);
    end else begin
      nrows = RNW'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      ncols = CNW'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      ncols = CNW'(MAX_COLS);
    end else begin
      ncols = CNW'(cols_in_use);
    end
    last_row = RAW'(nrows - RNW'(1));
    last_col = CAW'(ncols - CNW'(1));
  end

  // input fields
  logic [1:0] in_mode;
  logic [4:0] in_row;
  logic [6:0] in_col;
  logic       in_cell;
  logic       in_inside;
  logic       in_cell_op;

  assign in_mode    = s_tuser;
  assign in_row     = s_tdata[4:0];
  assign in_col     = s_tdata[11:5];
  assign in_cell    = s_tdata[12];
  assign in_inside  = (32'(in_row) < 32'(nrows)) && (32'(in_col) < 32'(ncols));
  assign in_cell_op = (in_mode == MODE_WRITE) || (in_mode == MODE_READ);

  // sequencer state
  logic [3:0]          state;
  logic [1:0]          mode_q;
  logic [RAW-1:0]      row_q;
  logic [CAW-1:0]      col_q;
  logic                cell_q;
  logic [RAW-1:0]      r;
  logic [CAW-1:0]      c;
  logic [12:0]         live;
  logic [MAX_COLS-1:0] prev_row;
  logic [MAX_COLS-1:0] cur_row;
  logic [MAX_COLS-1:0] next_row;
  logic [MAX_COLS-1:0] first_row;
  logic [MAX_COLS-1:0] new_row;
  logic                res_cell;
  logic [12:0]         res_live;
  logic                res_status;

  // memory controls
  logic                mem_wr_en;
  logic [RAW-1:0]      mem_wr_addr;
  logic [MAX_COLS-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [RAW-1:0]      mem_rd_addr;
  logic [MAX_COLS-1:0] mem_rd_data;
  logic [MAX_COLS-1:0] row_mod;
  logic                alive;
  logic                out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    row_mod         = mem_rd_data;
    row_mod[col_q]  = cell_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = r;
    mem_wr_data = new_row;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_cell_op && in_inside) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = RAW'(in_row);
          end else if (in_mode == MODE_STEP) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = last_row;
          end
        end
      end
      ST_ACC: begin
        if (mode_q == MODE_WRITE) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = row_q;
          mem_wr_data = row_mod;
        end
      end
      ST_LD_PREV: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
      end
      ST_NEXT_RD: begin
        if (r != last_row) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = r + RAW'(1);
        end
      end
      ST_WB: begin
        mem_wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // in ST_OUT the output register is reloaded as soon as it frees up
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode_q     <= in_mode;
            row_q      <= RAW'(in_row);
            col_q      <= CAW'(in_col);
            cell_q     <= in_cell;
            res_cell   <= 1'b0;
            res_live   <= '0;
            res_status <= in_cell_op && !in_inside;
            live       <= '0;
            if (in_cell_op) begin
              if (in_inside) begin
                state <= ST_ACC;
              end else begin
                state <= ST_OUT;
              end
            end else if (in_mode == MODE_STEP) begin
              state <= ST_LD_PREV;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_ACC: begin
          if (mode_q == MODE_READ) begin
            res_cell <= mem_rd_data[col_q];
          end
          state <= ST_OUT;
        end
        ST_LD_PREV: begin
          prev_row <= mem_rd_data;
          state    <= ST_LD_FIRST;
        end
        ST_LD_FIRST: begin
          cur_row   <= mem_rd_data;
          first_row <= mem_rd_data;
          r         <= '0;
          state     <= ST_NEXT_RD;
        end
        ST_NEXT_RD: begin
          new_row <= cur_row;
          c       <= '0;
          if (r == last_row) begin
            // last row wraps onto the original of row 0
            next_row <= first_row;
            state    <= ST_SWEEP;
          end else begin
            state <= ST_NEXT_WAIT;
          end
        end
        ST_NEXT_WAIT: begin
          next_row <= mem_rd_data;
          state    <= ST_SWEEP;
        end
        ST_SWEEP: begin
          new_row[c] <= alive;
          live       <= live + 13'(alive);
          if (c == last_col) begin
            state <= ST_WB;
          end else begin
            c <= c + CAW'(1);
          end
        end
        ST_WB: begin
          prev_row <= cur_row;
          cur_row  <= next_row;
          if (r == last_row) begin
            res_live <= live;
            state    <= ST_OUT;
          end else begin
            r     <= r + RAW'(1);
            state <= ST_NEXT_RD;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_live, res_cell};
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lla_row_mem #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lla_cell_unit #(
    .MAX_COLS (MAX_COLS)
  ) u_cell (
    .prev_row (prev_row),
    .cur_row  (cur_row),
    .next_row (next_row),
    .col      (c),
    .ncols    (ncols),
    .rules    (rules),
    .alive    (alive)
  );

endmodule

FILE: bench/lla_result_checker.sv
`timescale 1ns / 100ps

// Watches the config port and both streams, keeps its own copy of the board
// and rules, and checks every output transfer against the oldest prediction.
module lla_result_checker
  import lla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // row[4:0], col[11:5], cell_in[12], zero fill
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // cell_out[0], live_count[13:1], zero fill
  input  logic [0:0]  m_tuser,   // status[0]
  output int          errors,
  output int          pending,
  output int          items_seen,
  output int          steps_seen,
  output int          outside_seen
);

  typedef struct packed {
    logic        cell_out;
    logic [12:0] live_count;
    logic        status;
  } outcome_t;

  bit          board [MaxRowsDef][MaxColsDef];
  logic [3:0]  surv_lo, surv_hi, born_lo, born_hi;
  logic [5:0]  rows_cfg;
  logic [7:0]  cols_cfg;
  outcome_t    outcome_q[$];
  outcome_t    want, got;
  int          err_cnt = 0;
  int          item_cnt = 0;
  int          step_cnt = 0;
  int          outside_cnt = 0;

  function automatic int unsigned fit_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // wrapped neighbors are counted as addressed, so tiny grids hit cells more than once
  function automatic int unsigned count_around(int unsigned r, int unsigned c,
                                               int unsigned nr, int unsigned nc);
    int unsigned rs[3];
    int unsigned cs[3];
    int unsigned sum;
    rs[0] = (r == 0) ? nr - 1 : r - 1;
    rs[1] = r;
    rs[2] = (r + 1 >= nr) ? 0 : r + 1;
    cs[0] = (c == 0) ? nc - 1 : c - 1;
    cs[1] = c;
    cs[2] = (c + 1 >= nc) ? 0 : c + 1;
    sum = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        sum += board[rs[a]][cs[b]];
    return sum - board[r][c];
  endfunction

  function automatic logic [12:0] advance_board(int unsigned nr, int unsigned nc);
    bit          fresh [MaxRowsDef][MaxColsDef];
    int unsigned n;
    int unsigned live;
    bit          alive;
    fresh = board;
    live = 0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = count_around(r, c, nr, nc);
        if (board[r][c]) alive = (n >= surv_lo) && (n <= surv_hi);
        else alive = (n >= born_lo) && (n <= born_hi);
        fresh[r][c] = alive;
        live += alive;
      end
    end
    board = fresh;
    return live[12:0];
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] kind, logic [4:0] r,
                                               logic [6:0] c, logic v);
    outcome_t    o;
    int unsigned nr;
    int unsigned nc;
    bit          in_grid;
    o = '0;
    nr = fit_size(rows_cfg, MaxRowsDef);
    nc = fit_size(cols_cfg, MaxColsDef);
    in_grid = (r < nr) && (c < nc);
    case (kind)
      MODE_WRITE, MODE_READ: begin
        if (!in_grid) begin
          o.status = 1'b1;
          outside_cnt++;
        end else if (kind == MODE_WRITE) begin
          board[r][c] = v;
        end else begin
          o.cell_out = board[r][c];
        end
      end
      MODE_STEP: begin
        o.live_count = advance_board(nr, nc);
        step_cnt++;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MaxRowsDef; r++)
        for (int c = 0; c < MaxColsDef; c++)
          board[r][c] = 1'b0;
      surv_lo  = SURVIVE_MIN_RST;
      surv_hi  = SURVIVE_MAX_RST;
      born_lo  = BIRTH_MIN_RST;
      born_hi  = BIRTH_MAX_RST;
      rows_cfg = ROWS_IN_USE_RST;
      cols_cfg = COLS_IN_USE_RST;
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SURVIVE_MIN: surv_lo  = cfg_data[3:0];
          REG_SURVIVE_MAX: surv_hi  = cfg_data[3:0];
          REG_BIRTH_MIN:   born_lo  = cfg_data[3:0];
          REG_BIRTH_MAX:   born_hi  = cfg_data[3:0];
          REG_ROWS_IN_USE: rows_cfg = cfg_data[5:0];
          REG_COLS_IN_USE: cols_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(predict_outcome(s_tuser, s_tdata[4:0], s_tdata[11:5],
                                            s_tdata[12]));
        item_cnt++;
      end
      if (m_tvalid && m_tready) begin
        got.cell_out   = m_tdata[0];
        got.live_count = m_tdata[13:1];
        got.status     = m_tuser[0];
        if (outcome_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected output transfer: cell_out=%0d live_count=%0d status=%0d",
                     got.cell_out, got.live_count, got.status);
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (got.cell_out !== want.cell_out || got.live_count !== want.live_count ||
              got.status !== want.status) begin
            if (err_cnt < 10)
              $display("mismatch: expected cell/live/status %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.cell_out, want.live_count, want.status,
                       got.cell_out, got.live_count, got.status);
            err_cnt++;
          end
        end
      end
    end
    errors       <= err_cnt;
    pending      <= outcome_q.size();
    items_seen   <= item_cnt;
    steps_seen   <= step_cnt;
    outside_seen <= outside_cnt;
  end

endmodule

FILE: bench/tb_life_like_automaton_step_top.sv
`timescale 1ns / 100ps

module tb_life_like_automaton_step_top;
  import lla_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_SURVIVE_MIN;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic [1:0]  s_tuser = MODE_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  int          errors, pending, items_seen, steps_seen, outside_seen;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned eff_rows = 25;
  int unsigned eff_cols = 80;
  int          setups = 0;

  always #5 clk = ~clk;

  life_like_automaton_step_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  lla_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .pending     (pending),
    .items_seen  (items_seen),
    .steps_seen  (steps_seen),
    .outside_seen(outside_seen)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (!m_tready) begin
      if (stall_left == 0) m_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [4:0] r,
                           input logic [6:0] c, input logic v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, v, c, r};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input until every predicted result has been transferred
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // upper data bits are junk on purpose, the registers keep only their width
  task automatic load_setup(input logic [3:0] smin, input logic [3:0] smax,
                            input logic [3:0] bmin, input logic [3:0] bmax,
                            input logic [5:0] nr, input logic [7:0] nc);
    put_reg(REG_SURVIVE_MIN, {4'($urandom), smin});
    put_reg(REG_SURVIVE_MAX, {4'($urandom), smax});
    put_reg(REG_BIRTH_MIN, {4'($urandom), bmin});
    put_reg(REG_BIRTH_MAX, {4'($urandom), bmax});
    put_reg(REG_ROWS_IN_USE, {2'($urandom), nr});
    put_reg(REG_COLS_IN_USE, nc);
    cfg_we <= 1'b0;
    eff_rows = (nr == 0) ? 1 : (nr > MaxRowsDef) ? MaxRowsDef : nr;
    eff_cols = (nc == 0) ? 1 : (nc > MaxColsDef) ? MaxColsDef : nc;
    setups++;
  endtask

  task automatic random_setup(input int phase);
    int unsigned pick;
    logic [3:0]  a, b, cc, d;
    logic [5:0]  nr;
    logic [7:0]  nc;
    pick = $urandom_range(0, 99);
    a  = 4'($urandom_range(0, 8));
    b  = 4'($urandom_range(0, 8));
    cc = 4'($urandom_range(0, 8));
    d  = 4'($urandom_range(0, 8));
    nr = 6'($urandom_range(3, 8));
    nc = 8'($urandom_range(3, 16));
    if (phase == 5) begin
      nr = 6'($urandom_range(32, 63));
      nc = 8'($urandom_range(128, 255));
    end else if (pick < 20) begin
      a = SURVIVE_MIN_RST; b = SURVIVE_MAX_RST;
      cc = BIRTH_MIN_RST; d = BIRTH_MAX_RST;
      nr = 6'($urandom_range(3, 12));
      nc = 8'($urandom_range(3, 24));
    end else if (pick < 32) begin
      nr = 6'($urandom_range(0, 2));
      nc = 8'($urandom_range(0, 3));
      a = 4'($urandom); b = 4'($urandom); cc = 4'($urandom); d = 4'($urandom);
    end else if (pick < 42) begin
      a = 4'($urandom); b = 4'($urandom); cc = 4'($urandom); d = 4'($urandom);
    end
    load_setup(a, b, cc, d, nr, nc);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [4:0]  r;
    logic [6:0]  c;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) begin
      r = 5'($urandom);
      c = 7'($urandom);
    end else begin
      r = 5'($urandom_range(0, eff_rows - 1));
      c = 7'($urandom_range(0, eff_cols - 1));
    end
    if (pick < 40) push_item(MODE_WRITE, r, c, 1'($urandom));
    else if (pick < 65) push_item(MODE_READ, r, c, 1'($urandom));
    else if (pick < 94) push_item(MODE_STEP, 5'($urandom), 7'($urandom), 1'($urandom));
    else push_item(MODE_SPARE, r, c, 1'($urandom));
    if ($urandom_range(0, 29) == 0) wait_quiet();
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset rules and size: four wrapped corners, a blinker, edges of the grid
    push_item(MODE_READ, 5'd0, 7'd0, 1'b0);
    push_item(MODE_WRITE, 5'd24, 7'd79, 1'b1);
    push_item(MODE_WRITE, 5'd24, 7'd0, 1'b1);
    push_item(MODE_WRITE, 5'd0, 7'd79, 1'b1);
    push_item(MODE_WRITE, 5'd0, 7'd0, 1'b1);
    push_item(MODE_WRITE, 5'd25, 7'd0, 1'b1);
    push_item(MODE_WRITE, 5'd0, 7'd80, 1'b1);
    push_item(MODE_WRITE, 5'd31, 7'd127, 1'b1);
    push_item(MODE_READ, 5'd31, 7'd127, 1'b1);
    push_item(MODE_WRITE, 5'd10, 7'd10, 1'b1);
    push_item(MODE_WRITE, 5'd10, 7'd11, 1'b1);
    push_item(MODE_WRITE, 5'd10, 7'd12, 1'b1);
    push_item(MODE_STEP, 5'd31, 7'd127, 1'b1);
    push_item(MODE_READ, 5'd9, 7'd11, 1'b0);
    push_item(MODE_STEP, 5'd0, 7'd0, 1'b0);
    push_item(MODE_READ, 5'd24, 7'd79, 1'b0);
    push_item(MODE_SPARE, 5'd31, 7'd127, 1'b1);
    push_item(MODE_WRITE, 5'd10, 7'd11, 1'b0);
    wait_quiet();

    // whole store, then sizes beyond the store
    load_setup(4'd2, 4'd3, 4'd3, 4'd3, 6'd32, 8'd128);
    push_item(MODE_WRITE, 5'd31, 7'd127, 1'b1);
    push_item(MODE_READ, 5'd31, 7'd127, 1'b0);
    push_item(MODE_STEP, 5'd0, 7'd0, 1'b0);
    wait_quiet();
    load_setup(4'd0, 4'd8, 4'd8, 4'd8, 6'd63, 8'd255);
    push_item(MODE_STEP, 5'd5, 7'd5, 1'b1);
    wait_quiet();

    // zero rows acts as one: a lone cell sees itself eight times
    load_setup(4'd0, 4'd8, 4'd0, 4'd0, 6'd0, 8'd1);
    push_item(MODE_WRITE, 5'd0, 7'd0, 1'b1);
    push_item(MODE_STEP, 5'd0, 7'd0, 1'b0);
    push_item(MODE_READ, 5'd1, 7'd0, 1'b0);
    wait_quiet();
    // crossed survive range, birth range beyond eight
    load_setup(4'd15, 4'd0, 4'd0, 4'd15, 6'd2, 8'd2);
    push_item(MODE_WRITE, 5'd1, 7'd1, 1'b1);
    push_item(MODE_STEP, 5'd0, 7'd0, 1'b0);
    push_item(MODE_READ, 5'd0, 7'd1, 1'b0);
    wait_quiet();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 8) calm <= 1'b1;
      random_setup(ph);
      n = (ph == 5) ? 4 : 8;
      repeat ($urandom_range(3, 5))
        push_item(MODE_WRITE, 5'($urandom_range(0, eff_rows - 1)),
                  7'($urandom_range(0, eff_cols - 1)), 1'b1);
      repeat (n) random_item();
      wait_quiet();
    end

    $display("covered %0d items: %0d generation steps, %0d out-of-grid accesses",
             items_seen, steps_seen, outside_seen);
    $display("rules and grid size changed %0d times, from 1x1 up to the whole store",
             setups);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: life_like_automaton_step_top.f
src/lla_pkg.sv
src/lla_row_mem.sv
src/lla_cell_unit.sv
src/life_like_automaton_step_top.sv
bench/lla_result_checker.sv
bench/tb_life_like_automaton_step_top.sv
